>>> hdl/gbld_pkg.sv
package gbld_pkg;

	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned SCALE_SH = 12;

	localparam logic [3:0] BAR_STEPS = 4'd9;
	localparam logic [3:0] LED_TOP   = 4'd7;

	// gesture codes
	localparam logic [2:0] GEST_NONE    = 3'd0;
	localparam logic [2:0] GEST_SINGLE  = 3'd1;
	localparam logic [2:0] GEST_DOUBLE  = 3'd2;
	localparam logic [2:0] GEST_LONG    = 3'd3;
	localparam logic [2:0] GEST_IGNORED = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_SHORT_LIMIT   = 2'd0;
	localparam logic [1:0] REG_LONG_LIMIT    = 2'd1;
	localparam logic [1:0] REG_DOUBLE_WINDOW = 2'd2;

	localparam logic [CFG_W-1:0] SHORT_RST  = 16'd300;
	localparam logic [CFG_W-1:0] LONG_RST   = 16'd500;
	localparam logic [CFG_W-1:0] WINDOW_RST = 16'd500;

	typedef struct packed {
		logic                button_down;
		logic [SAMPLE_W-1:0] sample_ch0;
		logic [SAMPLE_W-1:0] sample_ch1;
		logic [SAMPLE_W-1:0] sample_ch2;
	} in_item_t;

	typedef struct packed {
		logic [7:0] led_pattern;
		logic [1:0] channel_shown;
		logic       binary_mode;
		logic       sweep_active;
		logic [2:0] gesture;
	} out_item_t;

	typedef struct packed {
		logic [CFG_W-1:0] short_limit_ms;
		logic [CFG_W-1:0] long_limit_ms;
		logic [CFG_W-1:0] double_window_ms;
	} cfg_t;

	// per-channel values worked out at the input register
	typedef struct packed {
		logic [CFG_W-1:0] scaled;  // (sample * |long - short|) >> 12
		logic [3:0]       bar;     // (sample * 9) >> 12
		logic [7:0]       upper;   // sample[11:4]
	} ch_prep_t;

	typedef struct packed {
		logic               button_down;
		ch_prep_t [2:0]     ch;
	} prep_t;

	function automatic logic [7:0] bar_mask(input logic [3:0] count);
		logic [8:0] m;
		m = (9'd1 << count) - 9'd1;
		if (count >= 4'd8) begin
			return 8'hFF;
		end
		return m[7:0];
	endfunction

endpackage

>>> hdl/gbld_front.sv
module gbld_front
	import gbld_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  cfg_t     cfg,
	input  logic     adv,
	output logic     valid_s1,
	output prep_t    prep_s1
);

	logic [CFG_W-1:0] diff;
	logic             load;
	prep_t            prep;
	logic [SAMPLE_W-1:0] smp [3];

	assign in_stall = valid_s1 && !adv;
	assign load     = in_valid && !in_stall;

	assign diff = (cfg.long_limit_ms >= cfg.short_limit_ms) ?
		(cfg.long_limit_ms - cfg.short_limit_ms) :
		(cfg.short_limit_ms - cfg.long_limit_ms);

	assign smp[0] = in_data.sample_ch0;
	assign smp[1] = in_data.sample_ch1;
	assign smp[2] = in_data.sample_ch2;

	always_comb begin
		logic [SAMPLE_W+CFG_W-1:0] prod;
		logic [15:0]               barp;
		prep.button_down = in_data.button_down;
		for (int k = 0; k < 3; k++) begin
			prod = (SAMPLE_W+CFG_W)'(smp[k]) * (SAMPLE_W+CFG_W)'(diff);
			barp = 16'(smp[k]) * 16'(BAR_STEPS);
			prep.ch[k].scaled = prod[SAMPLE_W+CFG_W-1:SCALE_SH];
			prep.ch[k].bar    = barp[15:12];
			prep.ch[k].upper  = smp[k][11:4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prep_s1 <= prep;
		end
	end

endmodule

>>> hdl/gbld_core.sv
module gbld_core
	import gbld_pkg::*;
#(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_s1,
	input  prep_t     prep_s1,
	input  cfg_t      cfg,
	output logic      adv,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic [TIME_WIDTH-1:0] tick_q, press_start_q, last_rel_q, last_step_q;
	logic                  held_q, bits_q, sweep_q, up_q;
	logic [1:0]            clicks_q, ch_q;
	logic [2:0]            pos_q;
	logic [7:0]            latch_q;

	logic [TIME_WIDTH-1:0] tick, press_start_n, last_rel_n, last_step_n;
	logic                  held_n, bits_n, sweep_n, up_n;
	logic [1:0]            clicks_n, ch_n;
	logic [2:0]            pos_n;
	logic [7:0]            latch_n;
	logic [2:0]            gest;

	logic [TIME_WIDTH-1:0] short_w, long_w, window_w;
	out_item_t             res;

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign short_w  = TIME_WIDTH'(cfg.short_limit_ms);
	assign long_w   = TIME_WIDTH'(cfg.long_limit_ms);
	assign window_w = TIME_WIDTH'(cfg.double_window_ms);

	always_comb begin
		logic [TIME_WIDTH-1:0] dur, since_rel, since_step;
		logic [1:0]            clicks_inc;
		ch_prep_t              chp;
		logic [CFG_W-1:0]      delay;
		logic [3:0]            p;

		tick          = tick_q + TIME_WIDTH'(1);
		press_start_n = press_start_q;
		last_rel_n    = last_rel_q;
		last_step_n   = last_step_q;
		held_n        = held_q;
		bits_n        = bits_q;
		sweep_n       = sweep_q;
		up_n          = up_q;
		clicks_n      = clicks_q;
		ch_n          = ch_q;
		pos_n         = pos_q;
		latch_n       = latch_q;
		gest          = GEST_NONE;

		dur        = tick - press_start_q;
		since_rel  = tick - last_rel_q;
		clicks_inc = clicks_q + 2'd1;

		if (prep_s1.button_down && !held_q) begin
			held_n        = 1'b1;
			press_start_n = tick;
		end
		if (!prep_s1.button_down && held_q) begin
			held_n = 1'b0;
			if (dur < short_w) begin
				if (since_rel < window_w) begin
					clicks_n = clicks_inc;
					gest     = GEST_IGNORED;
					if (clicks_inc == 2'd2) begin
						sweep_n = !sweep_q;
						if (!sweep_q) begin
							pos_n       = 3'd0;
							up_n        = 1'b1;
							last_step_n = tick;
						end
						clicks_n = 2'd0;
						gest     = GEST_DOUBLE;
					end
				end else begin
					if (!sweep_q) begin
						bits_n = !bits_q;
					end
					clicks_n = 2'd1;
					gest     = GEST_SINGLE;
				end
				last_rel_n = tick;
			end else if (dur >= long_w) begin
				sweep_n  = 1'b0;
				clicks_n = 2'd0;
				gest     = GEST_LONG;
				case (ch_q)
					2'd0:    ch_n = 2'd1;
					2'd1:    ch_n = 2'd2;
					2'd2:    ch_n = 2'd0;
					default: ch_n = 2'd1;
				endcase
			end else begin
				gest = GEST_IGNORED;
			end
		end

		// a lone click expires once the window has passed
		since_rel = tick - last_rel_n;
		if (since_rel > window_w && clicks_n == 2'd1) begin
			clicks_n = 2'd0;
		end

		case (ch_n)
			2'd1:    chp = prep_s1.ch[1];
			2'd2:    chp = prep_s1.ch[2];
			default: chp = prep_s1.ch[0];
		endcase

		if (cfg.long_limit_ms >= cfg.short_limit_ms) begin
			delay = cfg.long_limit_ms - chp.scaled;
		end else begin
			delay = cfg.long_limit_ms + chp.scaled;
		end

		since_step = tick - last_step_n;
		p          = {1'b0, pos_n} + 4'd1;
		if (sweep_n) begin
			if (since_step >= TIME_WIDTH'(delay)) begin
				last_step_n = tick;
				latch_n     = 8'd1 << pos_n;
				if (up_n) begin
					if (p >= LED_TOP) begin
						pos_n = LED_TOP[2:0];
						up_n  = 1'b0;
					end else begin
						pos_n = p[2:0];
					end
				end else if (pos_n == 3'd0) begin
					up_n = 1'b1;
				end else begin
					pos_n = pos_n - 3'd1;
				end
			end
		end else if (!bits_n) begin
			latch_n = bar_mask(chp.bar);
		end else begin
			latch_n = chp.upper;
		end

		res.led_pattern   = latch_n;
		res.channel_shown = ch_n;
		res.binary_mode   = bits_n;
		res.sweep_active  = sweep_n;
		res.gesture       = gest;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= '0;
			press_start_q <= '0;
			last_rel_q    <= '0;
			last_step_q   <= '0;
			held_q        <= 1'b0;
			bits_q        <= 1'b1;
			sweep_q       <= 1'b0;
			up_q          <= 1'b1;
			clicks_q      <= 2'd0;
			ch_q          <= 2'd0;
			pos_q         <= 3'd0;
			latch_q       <= 8'd0;
		end else if (adv) begin
			tick_q        <= tick;
			press_start_q <= press_start_n;
			last_rel_q    <= last_rel_n;
			last_step_q   <= last_step_n;
			held_q        <= held_n;
			bits_q        <= bits_n;
			sweep_q       <= sweep_n;
			up_q          <= up_n;
			clicks_q      <= clicks_n;
			ch_q          <= ch_n;
			pos_q         <= pos_n;
			latch_q       <= latch_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= res;
		end
	end

endmodule

>>> hdl/button_gesture_led_display_unit.sv
// Button gesture classifier and LED display driver.
// in channel: one transfer per millisecond tick, carrying the button level
//   and the three latest 12-bit converter samples.
// out channel: one result per tick with the LED bits, shown channel,
//   display mode, sweep state and the gesture released on that tick.
// cfg channel: always ready; index 0 short limit, 1 long limit, 2 double
//   window (ms). Write only while no tick is in flight.
// Path: the input is registered, then the result register behind the
//   gesture/display logic takes the tick once the output can accept it.
// Throughput: one tick per cycle while the output is not stalled; the state
//   update for a tick happens as it moves into the result register. The
//   scaling multiplies for all three channels run ahead of the input register.
// Stall: a stalled result holds; one more tick waits in the input register,
//   after which in_stall rises.
// Reset: limits return to 300/500/500, the tick count to zero, binary
//   display on, sweep off, channel 0, LEDs dark.
module button_gesture_led_display_unit
	import gbld_pkg::*;
#(
	parameter int unsigned TIME_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t  cfg_q;
	logic  valid_s1;
	prep_t prep_s1;
	logic  adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_limit_ms   <= SHORT_RST;
			cfg_q.long_limit_ms    <= LONG_RST;
			cfg_q.double_window_ms <= WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SHORT_LIMIT:   cfg_q.short_limit_ms   <= cfg_data;
				REG_LONG_LIMIT:    cfg_q.long_limit_ms    <= cfg_data;
				REG_DOUBLE_WINDOW: cfg_q.double_window_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	gbld_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.prep_s1  (prep_s1)
	);

	gbld_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.prep_s1   (prep_s1),
		.cfg       (cfg_q),
		.adv       (adv),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_gesture_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.gesture <= GEST_IGNORED))
		else $error("gesture code out of range");

	a_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.channel_shown != 2'd3))
		else $error("channel three shown");

	a_long_stops_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.gesture == GEST_LONG) |-> !out_data.sweep_active)
		else $error("sweep running after long press");

	a_no_lost_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1)
		else $error("held tick dropped from input register");
`endif

endmodule

>>> verif/testbench.sv
module testbench;
	import gbld_pkg::*;

	localparam int unsigned TIME_W       = 32;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned QUIET_LIMIT  = 4000;
	localparam int unsigned TICK_TARGET  = 1450;
	localparam int unsigned SEG_TICKS    = 110;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [1:0]       reg_idx;
		logic [CFG_W-1:0] reg_val;
		in_item_t         item;
		bit               has_want;
		out_item_t        want;
	} plan_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	button_gesture_led_display_unit #(.TIME_WIDTH(TIME_W)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// shadow registers and gesture/display state
	logic [CFG_W-1:0]  lim_short, lim_long, win_double;
	logic [TIME_W-1:0] t_now, t_press, t_release, t_step;
	logic              held, bits_mode, sweeping, going_up;
	logic [1:0]        clicks, chan;
	logic [2:0]        pos;
	logic [7:0]        leds;

	out_item_t   frames_due[$];
	plan_row_t   plan[$];
	int unsigned ticks_taken = 0;
	int unsigned ticks_sent  = 0;
	int unsigned writes_done = 0;
	int unsigned mismatches  = 0;
	int unsigned quiet       = 0;
	int unsigned send_pct    = 0;
	int unsigned stall_pct   = 0;
	bit          fixed_on    = 1'b0;
	out_item_t   fixed_frame = '0;

	function automatic void reset_model();
		lim_short  = SHORT_RST;
		lim_long   = LONG_RST;
		win_double = WINDOW_RST;
		t_now      = '0;
		t_press    = '0;
		t_release  = '0;
		t_step     = '0;
		held       = 1'b0;
		clicks     = '0;
		chan       = '0;
		bits_mode  = 1'b1;
		sweeping   = 1'b0;
		pos        = '0;
		going_up   = 1'b1;
		leds       = '0;
	endfunction

	function automatic out_item_t gesture_display_step(input in_item_t it);
		logic [2:0]          g;
		logic [TIME_W-1:0]   dur, since_rel, since_step, delay, span, s32;
		logic [SAMPLE_W-1:0] s;
		logic [3:0]          p, cnt;
		logic [8:0]          mask;
		out_item_t           r;
		t_now = t_now + 1'b1;
		g = GEST_NONE;
		if (it.button_down && !held) begin
			held = 1'b1;
			t_press = t_now;
		end
		if (!it.button_down && held) begin
			dur = t_now - t_press;
			held = 1'b0;
			if (dur < lim_short) begin
				since_rel = t_now - t_release;
				if (since_rel < win_double) begin
					clicks = clicks + 2'd1;
					g = GEST_IGNORED;
					if (clicks == 2'd2) begin
						sweeping = !sweeping;
						if (sweeping) begin
							pos = '0;
							going_up = 1'b1;
							t_step = t_now;
						end
						clicks = '0;
						g = GEST_DOUBLE;
					end
				end else begin
					if (!sweeping)
						bits_mode = !bits_mode;
					clicks = 2'd1;
					g = GEST_SINGLE;
				end
				t_release = t_now;
			end else if (dur >= lim_long) begin
				sweeping = 1'b0;
				case (chan)
					2'd0: chan = 2'd1;
					2'd1: chan = 2'd2;
					2'd2: chan = 2'd0;
					default: chan = 2'd1;
				endcase
				clicks = '0;
				g = GEST_LONG;
			end else begin
				g = GEST_IGNORED;
			end
		end
		since_rel = t_now - t_release;
		if (since_rel > win_double && clicks == 2'd1)
			clicks = '0;

		case (chan)
			2'd1: s = it.sample_ch1;
			2'd2: s = it.sample_ch2;
			default: s = it.sample_ch0;
		endcase
		s32 = TIME_W'(s);

		if (sweeping) begin
			if (lim_long >= lim_short) begin
				span = TIME_W'(lim_long) - TIME_W'(lim_short);
				delay = TIME_W'(lim_long) - ((s32 * span) >> SCALE_SH);
			end else begin
				span = TIME_W'(lim_short) - TIME_W'(lim_long);
				delay = TIME_W'(lim_long) + ((s32 * span) >> SCALE_SH);
			end
			since_step = t_now - t_step;
			if (since_step >= delay) begin
				t_step = t_now;
				leds = 8'd1 << pos;
				if (going_up) begin
					p = {1'b0, pos} + 4'd1;
					if (p >= LED_TOP) begin
						p = LED_TOP;
						going_up = 1'b0;
					end
					pos = p[2:0];
				end else if (pos == 3'd0) begin
					going_up = 1'b1;
				end else begin
					pos = pos - 3'd1;
				end
			end
		end else if (!bits_mode) begin
			cnt = 4'((s32 * TIME_W'(BAR_STEPS)) >> SCALE_SH);
			mask = (9'd1 << cnt) - 9'd1;
			leds = mask[7:0];
		end else begin
			leds = s[11:4];
		end

		r.led_pattern   = leds;
		r.channel_shown = chan;
		r.binary_mode   = bits_mode;
		r.sweep_active  = sweeping;
		r.gesture       = g;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(negedge clk)
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin : monitor
		out_item_t due;
		bit        moved;
		moved = 1'b0;
		if (arst_n) begin
			// results first, so a result in the same cycle as a new tick is not
			// matched against that tick
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (frames_due.size() == 0) begin
					$display("%0t: unexpected result: expected none, got %h", $time, out_data);
					mismatches++;
				end else begin
					due = frames_due.pop_front();
					check_field("led_pattern", due.led_pattern, out_data.led_pattern);
					check_field("channel_shown", due.channel_shown, out_data.channel_shown);
					check_field("binary_mode", due.binary_mode, out_data.binary_mode);
					check_field("sweep_active", due.sweep_active, out_data.sweep_active);
					check_field("gesture", due.gesture, out_data.gesture);
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				due = gesture_display_step(in_data);
				if (fixed_on)
					due = fixed_frame;
				frames_due.push_back(due);
				ticks_taken++;
			end
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				case (cfg_index)
					REG_SHORT_LIMIT:   lim_short  = cfg_data;
					REG_LONG_LIMIT:    lim_long   = cfg_data;
					REG_DOUBLE_WINDOW: win_double = cfg_data;
					default: ;
				endcase
				writes_done++;
			end
			if (moved)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_tick(input in_item_t it, input bit has_want, input out_item_t want);
		int unsigned target;
		while (send_pct != 0 && $urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		fixed_on = has_want;
		fixed_frame = want;
		in_data <= it;
		in_valid <= 1'b1;
		target = ticks_taken + 1;
		do @(negedge clk); while (ticks_taken < target);
		ticks_sent++;
	endtask

	// hold off the sender until every result is back, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (frames_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		int unsigned target;
		drain();
		target = writes_done + 1;
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (writes_done < target);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		if ($urandom_range(3) == 0)
			return $urandom_range(1) ? 12'hFFF : 12'h000;
		return SAMPLE_W'($urandom_range(4095));
	endfunction

	function automatic in_item_t rand_tick(input logic down);
		in_item_t it;
		it.button_down = down;
		it.sample_ch0 = rand_sample();
		it.sample_ch1 = rand_sample();
		it.sample_ch2 = rand_sample();
		return it;
	endfunction

	function automatic void plan_tick(input logic down, input logic [11:0] a, input logic [11:0] b,
			input logic [11:0] c, input bit has_want = 1'b0, input out_item_t want = '0);
		plan_row_t row;
		row.kind = ROW_TICK;
		row.reg_idx = '0;
		row.reg_val = '0;
		row.item = '{button_down: down, sample_ch0: a, sample_ch1: b, sample_ch2: c};
		row.has_want = has_want;
		row.want = want;
		plan.push_back(row);
	endfunction

	function automatic void plan_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		plan_row_t row;
		row.kind = ROW_WRITE;
		row.reg_idx = idx;
		row.reg_val = val;
		row.item = '0;
		row.has_want = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endfunction

	function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
			input int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	initial begin : main
		int          seg;
		int unsigned seg_start, held_n, gap_n, lo, hi, k;
		reset_model();

		// binary display straight out of reset
		plan_tick(1'b0, 12'hFFF, 12'h000, 12'h000, 1'b1, '{8'hFF, 2'd0, 1'b1, 1'b0, GEST_NONE});
		plan_tick(1'b0, 12'h000, 12'hFFF, 12'hFFF, 1'b1, '{8'h00, 2'd0, 1'b1, 1'b0, GEST_NONE});
		plan_tick(1'b0, 12'h0F0, 12'h5A5, 12'hA5A, 1'b1, '{8'h0F, 2'd0, 1'b1, 1'b0, GEST_NONE});
		// quick press before the window has run out after reset: count only
		plan_tick(1'b1, 12'h800, 12'h123, 12'hFED);
		plan_tick(1'b0, 12'h800, 12'h123, 12'hFED, 1'b1,
			'{8'h80, 2'd0, 1'b1, 1'b0, GEST_IGNORED});
		// second quick press starts the sweep, third only counts
		plan_tick(1'b1, 12'hFFF, 12'h000, 12'h7FF);
		plan_tick(1'b0, 12'hFFF, 12'h000, 12'h7FF);
		plan_tick(1'b1, 12'h000, 12'hFFF, 12'h800);
		plan_tick(1'b0, 12'h000, 12'hFFF, 12'h800);
		plan_tick(1'b0, 12'hFFF, 12'hFFF, 12'hFFF);
		// limits reversed: sweep delay grows with the sample
		plan_write(REG_SHORT_LIMIT, 16'd5);
		plan_write(REG_LONG_LIMIT, 16'd2);
		plan_write(REG_DOUBLE_WINDOW, 16'd0);
		for (int i = 0; i < 6; i++)
			plan_tick(1'b0, (i % 2) ? 12'hFFF : 12'h000, 12'h3C3, 12'hC3C);
		// long press: next channel, sweep stops
		plan_write(REG_SHORT_LIMIT, 16'd0);
		plan_tick(1'b1, 12'h111, 12'hABC, 12'h222);
		plan_tick(1'b1, 12'h111, 12'hABC, 12'h222);
		plan_tick(1'b0, 12'h111, 12'hABC, 12'h222);
		plan_write(REG_SHORT_LIMIT, 16'hFFFF);
		plan_write(REG_LONG_LIMIT, 16'hFFFF);
		plan_write(REG_DOUBLE_WINDOW, 16'hFFFF);
		plan_tick(1'b1, 12'h000, 12'hF0F, 12'h0F0);
		plan_tick(1'b0, 12'h000, 12'hF0F, 12'h0F0);
		plan_tick(1'b1, 12'hFFF, 12'h0F0, 12'hF0F);
		plan_tick(1'b0, 12'hFFF, 12'h0F0, 12'hF0F);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE)
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			else
				send_tick(plan[i].item, plan[i].has_want, plan[i].want);
		end

		seg = 0;
		while (ticks_sent < TICK_TARGET) begin
			case (seg % 4)
				0: begin send_pct = 0;  stall_pct = 0;  end
				1: begin send_pct = 53; stall_pct = 0;  end
				2: begin send_pct = 0;  stall_pct = 53; end
				default: begin send_pct = 32; stall_pct = 32; end
			endcase
			if (seg == 0) begin
				write_reg(REG_SHORT_LIMIT, SHORT_RST);
				write_reg(REG_LONG_LIMIT, LONG_RST);
				write_reg(REG_DOUBLE_WINDOW, WINDOW_RST);
			end else begin
				case ((seg - 1) % 5)
					0: begin
						lo = $urandom_range(15, 2);
						write_reg(REG_SHORT_LIMIT, CFG_W'(lo));
						write_reg(REG_LONG_LIMIT, CFG_W'(lo + $urandom_range(15)));
						write_reg(REG_DOUBLE_WINDOW, CFG_W'($urandom_range(40, 3)));
					end
					1: begin
						lo = $urandom_range(10, 1);
						write_reg(REG_LONG_LIMIT, CFG_W'(lo));
						write_reg(REG_SHORT_LIMIT, CFG_W'(lo + $urandom_range(12, 1)));
						write_reg(REG_DOUBLE_WINDOW, CFG_W'($urandom_range(40, 3)));
					end
					2: begin
						write_reg(REG_SHORT_LIMIT, 16'h0000);
						write_reg(REG_LONG_LIMIT, 16'h0000);
						write_reg(REG_DOUBLE_WINDOW, 16'h0000);
					end
					3: begin
						write_reg(REG_SHORT_LIMIT, 16'hFFFF);
						write_reg(REG_LONG_LIMIT, 16'hFFFF);
						write_reg(REG_DOUBLE_WINDOW, 16'hFFFF);
					end
					default: begin
						write_reg(REG_SHORT_LIMIT, CFG_W'($urandom_range(20, 1)));
						write_reg(REG_LONG_LIMIT, 16'h0000);
						write_reg(REG_DOUBLE_WINDOW, 16'hFFFF);
					end
				endcase
			end

			seg_start = ticks_sent;
			while (ticks_sent - seg_start < SEG_TICKS && ticks_sent < TICK_TARGET) begin
				k = $urandom_range(9);
				if (k < 8) begin
					if (k < 5) begin
						hi = (lim_short > 1) ? clamp(int'(lim_short) - 1, 1, 40) : 1;
						held_n = $urandom_range(hi, 1);
					end else if (k < 7) begin
						if (lim_long > 600)
							held_n = $urandom_range(40, 1);
						else
							held_n = $urandom_range(int'(lim_long) + 3,
								(lim_long == 0) ? 1 : int'(lim_long));
					end else begin
						lo = (lim_short == 0) ? 1 : int'(lim_short);
						if (lim_long > lo && lo <= 600)
							held_n = $urandom_range(clamp(int'(lim_long) - 1, lo, 600), lo);
						else
							held_n = $urandom_range(10, 1);
					end
					repeat (held_n) send_tick(rand_tick(1'b1), 1'b0, '0);
				end else begin
					// button noise
					repeat ($urandom_range(8, 1))
						send_tick(rand_tick(1'($urandom_range(1))), 1'b0, '0);
				end
				if ($urandom_range(9) < 6)
					gap_n = $urandom_range(clamp(int'(win_double) / 2, 1, 40), 1);
				else
					gap_n = $urandom_range(clamp(int'(win_double) + 5, 1, 80), 1);
				repeat (gap_n) send_tick(rand_tick(1'b0), 1'b0, '0);
			end
			seg++;
		end

		drain();
		if (mismatches == 0 && frames_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
